@@ rtl/qdec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdec_pkg
// Shared types, constants and helpers of the multi-channel quadrature decoder.
// ----------------------------------------------------------------------------
package qdec_pkg;

  localparam int CHANNELS  = 4;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W     = 16;
  localparam int THR_W     = 15;
  localparam int PIN_W     = 4;
  localparam int PIN_IDX_W = 2;
  localparam int SEL_W     = 3;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [THR_W-1:0] ACCEL_HIGH_RESET = THR_W'(5);
  localparam logic [THR_W-1:0] ACCEL_LOW_RESET  = THR_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LOW  = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_POSITION  = 3'd0,
    OP_DELTA     = 3'd1,
    OP_ACCEL     = 3'd2,
    OP_RESET_POS = 3'd3,
    OP_START     = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_e;

  // Step per transition, indexed by {previous AB, current AB}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [1:0]       prev_ab;
  } chan_entry_t;

  typedef struct packed {
    logic              entry_we;
    logic              last_we;
    logic [CH_W-1:0]   addr;
    chan_entry_t       entry;
    logic [POS_W-1:0]  last_read;
  } mem_wr_t;

  typedef struct packed {
    logic              entry_we;
    logic              last_we;
    chan_entry_t       entry;
    logic [POS_W-1:0]  last_read;
    logic [POS_W-1:0]  result;
  } calc_out_t;

  // AB pair of one encoder, A in the high bit; encoders without pins read zero
  function automatic logic [1:0] sample_ab(logic [SEL_W-1:0] ch,
                                           logic [PIN_W-1:0] pa,
                                           logic [PIN_W-1:0] pb);
    logic [1:0] ab;
    ab = 2'b00;
    if (32'(ch) < PIN_W) begin
      ab = {pa[ch[PIN_IDX_W-1:0]], pb[ch[PIN_IDX_W-1:0]]};
    end
    return ab;
  endfunction

endpackage

@@ rtl/qdec_chan_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdec_chan_mem
// Per-channel state memories: {position, previous AB} and last-read position.
// Registered read; entries never written read as zero.
// ----------------------------------------------------------------------------
module qdec_chan_mem import qdec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [CH_W-1:0]   rd_addr_i,
  input  mem_wr_t           wr_i,
  output chan_entry_t       rd_entry_o,
  output logic [POS_W-1:0]  rd_last_o
);

  chan_entry_t      entry_mem [CHANNELS];
  logic [POS_W-1:0] last_mem  [CHANNELS];

  logic [CHANNELS-1:0] entry_vld_q;
  logic [CHANNELS-1:0] last_vld_q;
  chan_entry_t         rd_entry_q;
  logic [POS_W-1:0]    rd_last_q;
  logic                rd_entry_hit_q;
  logic                rd_last_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.entry_we) begin
      entry_mem[wr_i.addr] <= wr_i.entry;
    end
    if (wr_i.last_we) begin
      last_mem[wr_i.addr] <= wr_i.last_read;
    end
    if (rd_en_i) begin
      rd_entry_q <= entry_mem[rd_addr_i];
      rd_last_q  <= last_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q    <= '0;
      last_vld_q     <= '0;
      rd_entry_hit_q <= 1'b0;
      rd_last_hit_q  <= 1'b0;
    end else begin
      if (wr_i.entry_we) begin
        entry_vld_q[wr_i.addr] <= 1'b1;
      end
      if (wr_i.last_we) begin
        last_vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_entry_hit_q <= entry_vld_q[rd_addr_i];
        rd_last_hit_q  <= last_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_entry_hit_q ? rd_entry_q : '0;
  assign rd_last_o  = rd_last_hit_q ? rd_last_q : '0;

endmodule

@@ rtl/qdec_step_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdec_step_calc
// Modify stage: decode the AB transition, update position, form the result.
// ----------------------------------------------------------------------------
module qdec_step_calc import qdec_pkg::*; (
  input  opcode_e           op_i,
  input  logic [1:0]        ab_now_i,
  input  chan_entry_t       entry_i,
  input  logic [POS_W-1:0]  last_read_i,
  input  logic [THR_W-1:0]  thr_high_i,
  input  logic [THR_W-1:0]  thr_low_i,
  output calc_out_t         out_o
);

  logic signed [1:0]       step;
  logic [POS_W-1:0]        new_pos;
  logic [POS_W-1:0]        delta;
  logic signed [POS_W:0]   delta_s;
  logic signed [POS_W:0]   hi_s;
  logic signed [POS_W:0]   lo_s;
  logic [POS_W-1:0]        scaled;

  always_comb begin
    step    = STEP_TABLE[{entry_i.prev_ab, ab_now_i}];
    new_pos = entry_i.pos + POS_W'($signed(step));
    delta   = new_pos - last_read_i;
    delta_s = $signed({delta[POS_W-1], delta});
    hi_s    = $signed({2'b00, thr_high_i});
    lo_s    = $signed({2'b00, thr_low_i});

    // first matching test decides
    if (delta_s > hi_s) begin
      scaled = {delta[POS_W-3:0], 2'b00};
    end else if (delta_s > lo_s) begin
      scaled = {delta[POS_W-2:0], 1'b0};
    end else if (delta_s < -hi_s) begin
      scaled = {delta[POS_W-3:0], 2'b00};
    end else if (delta_s < -lo_s) begin
      scaled = {delta[POS_W-2:0], 1'b0};
    end else begin
      scaled = delta;
    end

    out_o.entry_we  = 1'b1;
    out_o.last_we   = 1'b0;
    out_o.entry     = '{pos: new_pos, prev_ab: ab_now_i};
    out_o.last_read = new_pos;
    out_o.result    = '0;

    case (op_i)
      OP_POSITION: begin
        out_o.result = new_pos;
      end
      OP_DELTA: begin
        out_o.last_we = 1'b1;
        out_o.result  = delta;
      end
      OP_ACCEL: begin
        out_o.last_we = 1'b1;
        out_o.result  = scaled;
      end
      OP_RESET_POS: begin
        // clear position, keep the AB history
        out_o.entry = '{pos: '0, prev_ab: entry_i.prev_ab};
      end
      default: begin
        out_o.entry_we = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/multi_channel_quadrature_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_quadrature_decoder_core
// x4 quadrature decoder for several encoders sharing one command port.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start_i with opcode_i, encoder_select_i and the sampled pins; the
//   command is taken when start_i is high and busy_o is low. Every command
//   returns one result on result_value_o, marked by result_valid_o for a
//   single cycle; the receiver cannot stall it.
//   Position, delta, accelerated delta and reset position of a valid encoder
//   do a read-modify-write on the channel memory: read at the accept edge,
//   modify and write back in the next cycle. The result strobe is registered
//   from the modify cycle and busy_o is high during that cycle, so a new
//   command is taken only once the write-back is done.
//   The first start clears all positions and captures every AB pair in a
//   sweep, one memory entry per cycle, with busy_o high.
//   A second start, an unknown opcode or an out-of-range encoder returns
//   zero in the cycle after accept and leaves busy_o low.
//   Reset clears all positions, AB history, last-read values and the start
//   flag, and loads the threshold defaults (high 5, low 2).
//   Threshold writes through cfg_we_i take effect at once; write only idle.
// ----------------------------------------------------------------------------
module multi_channel_quadrature_decoder_core import qdec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [THR_W-1:0]      cfg_data_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [SEL_W-1:0]      encoder_select_i,
  input  logic [PIN_W-1:0]      pins_a_i,
  input  logic [PIN_W-1:0]      pins_b_i,
  output logic                  result_valid_o,
  output logic signed [POS_W-1:0] result_value_o
);

  state_e             state_q, state_d;
  logic [THR_W-1:0]   thr_high_q, thr_low_q;
  logic               started_q, started_d;
  opcode_e            op_q, op_d;
  logic [SEL_W-1:0]   sel_q, sel_d;
  logic [PIN_W-1:0]   pa_q, pa_d, pb_q, pb_d;
  logic [CH_W-1:0]    cnt_q, cnt_d;
  logic               res_vld_q, res_vld_d;
  logic [POS_W-1:0]   res_q, res_d;

  logic               accept;
  logic               sel_ok;
  opcode_e            op_in;
  logic               rd_en;
  mem_wr_t            mem_wr;
  chan_entry_t        rd_entry;
  logic [POS_W-1:0]   rd_last;
  calc_out_t          calc;

  assign op_in  = opcode_e'(opcode_i);
  assign accept = start_i && (state_q == ST_IDLE);
  assign sel_ok = 32'(encoder_select_i) < CHANNELS;

  qdec_chan_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (encoder_select_i[CH_W-1:0]),
    .wr_i       (mem_wr),
    .rd_entry_o (rd_entry),
    .rd_last_o  (rd_last)
  );

  qdec_step_calc u_calc (
    .op_i        (op_q),
    .ab_now_i    (sample_ab(sel_q, pa_q, pb_q)),
    .entry_i     (rd_entry),
    .last_read_i (rd_last),
    .thr_high_i  (thr_high_q),
    .thr_low_i   (thr_low_q),
    .out_o       (calc)
  );

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    op_d      = op_q;
    sel_d     = sel_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    cnt_d     = cnt_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    rd_en     = 1'b0;
    mem_wr    = '0;
    busy_o    = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = op_in;
          sel_d = encoder_select_i;
          pa_d  = pins_a_i;
          pb_d  = pins_b_i;
          if ((op_in inside {OP_POSITION, OP_DELTA, OP_ACCEL, OP_RESET_POS}) &&
              sel_ok) begin
            rd_en   = 1'b1;
            state_d = ST_EXEC;
          end else begin
            res_vld_d = 1'b1;
            res_d     = '0;
            if (op_in == OP_START && !started_q) begin
              started_d = 1'b1;
              cnt_d     = '0;
              state_d   = ST_SWEEP;
            end
          end
        end
      end
      ST_EXEC: begin
        mem_wr.entry_we  = calc.entry_we;
        mem_wr.last_we   = calc.last_we;
        mem_wr.addr      = sel_q[CH_W-1:0];
        mem_wr.entry     = calc.entry;
        mem_wr.last_read = calc.last_read;
        res_vld_d        = 1'b1;
        res_d            = calc.result;
        state_d          = ST_IDLE;
      end
      ST_SWEEP: begin
        // zero the position and capture the AB pair of one channel per cycle
        mem_wr.entry_we = 1'b1;
        mem_wr.addr     = cnt_q;
        mem_wr.entry    = '{pos: '0, prev_ab: sample_ab(SEL_W'(cnt_q), pa_q, pb_q)};
        cnt_d           = cnt_q + CH_W'(1);
        if (32'(cnt_q) == CHANNELS - 1) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      started_q  <= 1'b0;
      cnt_q      <= '0;
      res_vld_q  <= 1'b0;
      thr_high_q <= ACCEL_HIGH_RESET;
      thr_low_q  <= ACCEL_LOW_RESET;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACCEL_HIGH: thr_high_q <= cfg_data_i;
          CFG_ACCEL_LOW:  thr_low_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    sel_q <= sel_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_value_o = $signed(res_q);

  // Assertions
  a_exec_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> $past(accept))
    else $error("modify cycle without a preceding memory read");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> ($past(accept) && !$past(rd_en)) || $past(state_q == ST_EXEC))
    else $error("result strobe without a finished transaction");

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("start flag dropped");

  a_sweep_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> started_q && (32'(cnt_q) < CHANNELS))
    else $error("start sweep out of range or repeated");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_wr.entry_we && !mem_wr.last_we)
    else $error("memory write while idle");

endmodule
